FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified property checks shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AGS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AGS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/agp_pkg.sv
// ----------------------------------------------------------------------------
// agp_pkg
// Shared constants, codes and types of the affine glyph sampler.
// ----------------------------------------------------------------------------
package agp_pkg;

  localparam int MAX_TEXT     = 16;
  localparam int FONT_BYTES   = 768;
  localparam int FRAME_WIDTH  = 1024;
  localparam int FRAME_HEIGHT = 1024;

  localparam int TEXT_AW  = $clog2(MAX_TEXT);
  localparam int FONT_AW  = $clog2(FONT_BYTES);
  localparam int FRAME_XW = $clog2(FRAME_WIDTH);
  localparam int FRAME_YW = $clog2(FRAME_HEIGHT);
  localparam int LEN_W    = $clog2(MAX_TEXT + 1);

  localparam int GLYPH_SIZE = 8;
  localparam int GLYPH_BITS = $clog2(GLYPH_SIZE);
  localparam int CHAR_FIRST = 32;
  localparam int CHAR_LAST  = 127;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 20;

  localparam logic [1:0] CMD_LOAD_FONT = 2'd0;
  localparam logic [1:0] CMD_LOAD_TEXT = 2'd1;
  localparam logic [1:0] CMD_LATCH     = 2'd2;
  localparam logic [1:0] CMD_SAMPLE    = 2'd3;

  localparam logic [CFG_AW-1:0] REG_COEF_A  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_COEF_B  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_COEF_C  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_COEF_D  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SHIFT_X = 3'd4;
  localparam logic [CFG_AW-1:0] REG_SHIFT_Y = 3'd5;
  localparam logic [CFG_AW-1:0] REG_TEXT_LEN = 3'd6;
  localparam logic [CFG_AW-1:0] REG_COLOR   = 3'd7;

  typedef struct packed {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    logic signed [15:0] d;
    logic signed [19:0] tx;
    logic signed [19:0] ty;
  } coef_t;

  typedef struct packed {
    logic signed [31:0] ia;
    logic signed [31:0] ib;
    logic signed [31:0] ic;
    logic signed [31:0] id;
    logic signed [39:0] itx;
    logic signed [39:0] ity;
    logic               singular;
  } inv_t;

endpackage

FILE: hdl/agp_ram.sv
// ----------------------------------------------------------------------------
// agp_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module agp_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/agp_inv.sv
// ----------------------------------------------------------------------------
// agp_inv
// Inverts the forward affine matrix: one shared multiplier builds the
// determinant and offset numerators, one radix-2 divider forms six quotients.
// ----------------------------------------------------------------------------
module agp_inv (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  agp_pkg::coef_t coef_i,
  output logic           busy_o,
  output logic           done_o,
  output agp_pkg::inv_t  inv_o
);

  localparam logic [2:0] IV_IDLE = 3'd0;
  localparam logic [2:0] IV_MUL  = 3'd1;
  localparam logic [2:0] IV_CHK  = 3'd2;
  localparam logic [2:0] IV_LOAD = 3'd3;
  localparam logic [2:0] IV_DIV  = 3'd4;
  localparam logic [2:0] IV_WB   = 3'd5;

  localparam int NUM_W = 53;
  localparam int DEN_W = 33;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int N_PROD = 6;
  localparam int LAST_JOB = 5;

  logic [2:0]              state_q;
  logic [2:0]              step_q;
  logic [2:0]              job_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [35:0]      prod_q;
  logic signed [32:0]      det_q;
  logic signed [36:0]      nx_q;
  logic signed [36:0]      ny_q;
  logic [NUM_W-1:0]        num_q;
  logic [DEN_W-1:0]        den_q;
  logic [DEN_W-1:0]        rem_q;
  logic                    neg_q;
  agp_pkg::inv_t           inv_q;

  logic signed [15:0]      ma;
  logic signed [19:0]      mb;
  logic signed [35:0]      prod;
  logic signed [53:0]      num_s;
  logic [NUM_W-1:0]        num_mag;
  logic [DEN_W-1:0]        den_mag;
  logic [DEN_W:0]          rem_sh;
  logic                    ge;
  logic signed [NUM_W:0]   q_s;
  logic [31:0]             q_sat32;
  logic [39:0]             q_sat40;

  // operand pairs: a*d, b*c, c*ty, d*tx, b*tx, a*ty
  always_comb begin
    case (step_q)
      3'd0: begin ma = coef_i.a; mb = 20'(coef_i.d);  end
      3'd1: begin ma = coef_i.b; mb = 20'(coef_i.c);  end
      3'd2: begin ma = coef_i.c; mb = coef_i.ty;      end
      3'd3: begin ma = coef_i.d; mb = coef_i.tx;      end
      3'd4: begin ma = coef_i.b; mb = coef_i.tx;      end
      3'd5: begin ma = coef_i.a; mb = coef_i.ty;      end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = 36'(ma) * 36'(mb);
  end

  always_comb begin
    case (job_q)
      3'd0:    num_s = 54'(coef_i.d) <<< 24;
      3'd1:    num_s = -(54'(coef_i.b) <<< 24);
      3'd2:    num_s = -(54'(coef_i.c) <<< 24);
      3'd3:    num_s = 54'(coef_i.a) <<< 24;
      3'd4:    num_s = 54'(nx_q) <<< 16;
      default: num_s = 54'(ny_q) <<< 16;
    endcase
    num_mag = num_s[53] ? NUM_W'(-num_s) : NUM_W'(num_s);
    den_mag = det_q[32] ? DEN_W'(-det_q) : DEN_W'(det_q);
  end

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    q_s = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
    if (q_s[NUM_W:31] == {(NUM_W - 30){q_s[NUM_W]}}) begin
      q_sat32 = q_s[31:0];
    end else begin
      q_sat32 = q_s[NUM_W] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    end
    if (q_s[NUM_W:39] == {(NUM_W - 38){q_s[NUM_W]}}) begin
      q_sat40 = q_s[39:0];
    end else begin
      q_sat40 = q_s[NUM_W] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= IV_IDLE;
      step_q       <= '0;
      job_q        <= '0;
      cnt_q        <= '0;
      inv_q        <= '{32'sd65536, 32'sd0, 32'sd0, 32'sd65536, 40'sd0, 40'sd0, 1'b0};
    end else begin
      case (state_q)
        IV_IDLE: begin
          if (start_i) begin
            state_q <= IV_MUL;
            step_q  <= '0;
          end
        end
        IV_MUL: begin
          step_q <= step_q + 3'd1;
          if (32'(step_q) == N_PROD) begin
            state_q <= IV_CHK;
          end
        end
        IV_CHK: begin
          if (det_q == '0) begin
            inv_q   <= '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 40'sd0, 40'sd0, 1'b1};
            state_q <= IV_IDLE;
          end else begin
            inv_q.singular <= 1'b0;
            job_q          <= '0;
            state_q        <= IV_LOAD;
          end
        end
        IV_LOAD: begin
          cnt_q   <= '0;
          state_q <= IV_DIV;
        end
        IV_DIV: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (32'(cnt_q) == NUM_W - 1) begin
            state_q <= IV_WB;
          end
        end
        IV_WB: begin
          case (job_q)
            3'd0:    inv_q.ia  <= q_sat32;
            3'd1:    inv_q.ib  <= q_sat32;
            3'd2:    inv_q.ic  <= q_sat32;
            3'd3:    inv_q.id  <= q_sat32;
            3'd4:    inv_q.itx <= q_sat40;
            default: inv_q.ity <= q_sat40;
          endcase
          job_q   <= job_q + 3'd1;
          state_q <= (32'(job_q) == LAST_JOB) ? IV_IDLE : IV_LOAD;
        end
        default: state_q <= IV_IDLE;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    if (state_q == IV_MUL) begin
      prod_q <= prod;
      // fold the product of the previous step
      case (step_q)
        3'd1: det_q <= 33'(prod_q);
        3'd2: det_q <= det_q - 33'(prod_q);
        3'd3: nx_q  <= 37'(prod_q);
        3'd4: nx_q  <= nx_q - 37'(prod_q);
        3'd5: ny_q  <= 37'(prod_q);
        3'd6: ny_q  <= ny_q - 37'(prod_q);
        default: ;
      endcase
    end
    if (state_q == IV_LOAD) begin
      num_q <= num_mag;
      den_q <= den_mag;
      rem_q <= '0;
      neg_q <= num_s[53] ^ det_q[32];
    end
    if (state_q == IV_DIV) begin
      rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
      num_q <= {num_q[NUM_W-2:0], ge};
    end
  end

  assign busy_o = (state_q != IV_IDLE);
  assign done_o = ((state_q == IV_CHK) && (det_q == '0)) ||
                  ((state_q == IV_WB) && (32'(job_q) == LAST_JOB));
  assign inv_o  = inv_q;

endmodule

FILE: hdl/affine_glyph_sampler_top.sv
// ----------------------------------------------------------------------------
// affine_glyph_sampler_top
// Text rasterizer through an inverse affine transform, with font and text RAMs.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (cmd plus fields) enter on in_valid_i / in_stall_o; every item
//   gives exactly one result item on out_valid_o / out_stall_i.
//   Configuration registers are written on cfg_we_i while the block is idle;
//   the user is bound to this; the block itself does not enforce it.
//   One item is in flight at a time; in_stall_o is high while it is worked on.
//   Steps from accept to result valid:
//     font or text load: RAM write, then output register load
//     sample: multiply, add, truncate, text RAM read, font RAM read, output
//     latch: the time is set by the shared radix-2 divider that forms six
//       53-bit quotients one bit per cycle
//   The next item can be taken in the cycle after the result loads, not before;
//   a new item is taken while a result waits in the output register.
//   When the receiver stalls, a finished result holds until the register frees.
//   Reset restores the identity inverse and register defaults; the font and
//   text RAMs hold no defined data until loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module affine_glyph_sampler_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [agp_pkg::CFG_AW-1:0]     cfg_index_i,
  input  logic [agp_pkg::CFG_DW-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     cmd_i,
  input  logic [9:0]                     store_index_i,
  input  logic [7:0]                     store_data_i,
  input  logic signed [11:0]             offset_x_i,
  input  logic signed [11:0]             offset_y_i,
  input  logic signed [11:0]             anchor_x_i,
  input  logic signed [11:0]             anchor_y_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           hit_o,
  output logic [7:0]                     pixel_value_o,
  output logic [agp_pkg::FRAME_XW-1:0]   frame_x_o,
  output logic [agp_pkg::FRAME_YW-1:0]   frame_y_o,
  output logic                           singular_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LATCH = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_SUM   = 3'd3;
  localparam logic [2:0] ST_TRN   = 3'd4;
  localparam logic [2:0] ST_TXT   = 3'd5;
  localparam logic [2:0] ST_FNT   = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  localparam int TXT_HI = agp_pkg::TEXT_AW + agp_pkg::GLYPH_BITS - 1;
  localparam int GLYPH_BITS_W = agp_pkg::GLYPH_BITS;

  // configuration
  agp_pkg::coef_t  coef_q;
  logic [4:0]      len_q;
  logic [7:0]      color_q;

  logic [2:0]      state_q, state_d;
  logic            in_acc;
  logic            out_free;

  logic signed [11:0] ox_q, oy_q, ax_q, ay_q;
  logic signed [43:0] mxa_q, myc_q, mxb_q, myd_q;
  logic signed [47:0] rx_q, ry_q;
  logic [GLYPH_BITS_W-1:0] col_q, row_q;
  logic            res_hit_q;
  logic [agp_pkg::FRAME_XW-1:0] res_fx_q;
  logic [agp_pkg::FRAME_YW-1:0] res_fy_q;

  logic            out_valid_q;
  logic            hit_q;
  logic [7:0]      pix_q;
  logic [agp_pkg::FRAME_XW-1:0] fx_q;
  logic [agp_pkg::FRAME_YW-1:0] fy_q;
  logic            sing_q;

  agp_pkg::inv_t   inv_st;
  logic            inv_busy;
  logic            inv_done;

  logic            font_we, text_we;
  logic [agp_pkg::FONT_AW-1:0] font_raddr;
  logic [7:0]      font_rdata, text_rdata;

  logic signed [31:0] bx, by;
  logic            in_box;
  logic [agp_pkg::LEN_W-1:0] len_sat;
  logic [agp_pkg::LEN_W+agp_pkg::GLYPH_BITS-1:0] lim;
  logic            ch_ok;
  logic [10:0]     faddr;
  logic            faddr_ok;
  logic            glyph_bit;
  logic signed [12:0] fx, fy;
  logic            frame_ok;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q    <= '{16'sd256, 16'sd0, 16'sd0, 16'sd256, 20'sd0, 20'sd0};
      len_q     <= '0;
      color_q   <= 8'd255;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        agp_pkg::REG_COEF_A:   coef_q.a  <= cfg_data_i[15:0];
        agp_pkg::REG_COEF_B:   coef_q.b  <= cfg_data_i[15:0];
        agp_pkg::REG_COEF_C:   coef_q.c  <= cfg_data_i[15:0];
        agp_pkg::REG_COEF_D:   coef_q.d  <= cfg_data_i[15:0];
        agp_pkg::REG_SHIFT_X:  coef_q.tx <= cfg_data_i[19:0];
        agp_pkg::REG_SHIFT_Y:  coef_q.ty <= cfg_data_i[19:0];
        agp_pkg::REG_TEXT_LEN: len_q     <= cfg_data_i[4:0];
        agp_pkg::REG_COLOR:    color_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  agp_inv u_inv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && (cmd_i == agp_pkg::CMD_LATCH)),
    .coef_i  (coef_q),
    .busy_o  (inv_busy),
    .done_o  (inv_done),
    .inv_o   (inv_st)
  );

  assign font_we = in_acc && (cmd_i == agp_pkg::CMD_LOAD_FONT) &&
                   (32'(store_index_i) < agp_pkg::FONT_BYTES);
  assign text_we = in_acc && (cmd_i == agp_pkg::CMD_LOAD_TEXT) &&
                   (32'(store_index_i) < agp_pkg::MAX_TEXT);

  agp_ram #(.DEPTH(agp_pkg::FONT_BYTES), .WIDTH(8)) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (font_we),
    .waddr_i (agp_pkg::FONT_AW'(store_index_i)),
    .wdata_i (store_data_i),
    .raddr_i (font_raddr),
    .rdata_o (font_rdata)
  );

  agp_ram #(.DEPTH(agp_pkg::MAX_TEXT), .WIDTH(8)) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (text_we),
    .waddr_i (agp_pkg::TEXT_AW'(store_index_i)),
    .wdata_i (store_data_i),
    .raddr_i (bx[TXT_HI:agp_pkg::GLYPH_BITS]),
    .rdata_o (text_rdata)
  );

  // truncate toward zero and bound to the text box
  always_comb begin
    bx = 32'(rx_q >>> 16) + 32'(rx_q[47] && (rx_q[15:0] != '0));
    by = 32'(ry_q >>> 16) + 32'(ry_q[47] && (ry_q[15:0] != '0));
    len_sat = (32'(len_q) > agp_pkg::MAX_TEXT) ? agp_pkg::LEN_W'(agp_pkg::MAX_TEXT)
                                                : agp_pkg::LEN_W'(len_q);
    lim    = {len_sat, {agp_pkg::GLYPH_BITS{1'b0}}};
    in_box = !bx[31] && !by[31] && (bx < 32'(lim)) &&
             (by < 32'(agp_pkg::GLYPH_SIZE));
  end

  // character and font address
  always_comb begin
    ch_ok      = (32'(text_rdata) >= agp_pkg::CHAR_FIRST) &&
                 (32'(text_rdata) <= agp_pkg::CHAR_LAST);
    faddr      = {8'(text_rdata - 8'(agp_pkg::CHAR_FIRST)), row_q};
    faddr_ok   = 32'(faddr) < agp_pkg::FONT_BYTES;
    font_raddr = agp_pkg::FONT_AW'(faddr);
  end

  always_comb begin
    glyph_bit = font_rdata[3'(agp_pkg::GLYPH_SIZE - 1) - col_q];
    fx        = 13'(ax_q) + 13'(ox_q);
    fy        = 13'(ay_q) + 13'(oy_q);
    frame_ok  = !fx[12] && !fy[12] && (32'(fx) < agp_pkg::FRAME_WIDTH) &&
                (32'(fy) < agp_pkg::FRAME_HEIGHT);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_i)
            agp_pkg::CMD_LATCH:  state_d = ST_LATCH;
            agp_pkg::CMD_SAMPLE: state_d = inv_st.singular ? ST_OUT : ST_MUL;
            default:             state_d = ST_OUT;
          endcase
        end
      end
      ST_LATCH: if (inv_done) state_d = ST_OUT;
      ST_MUL:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_TRN;
      ST_TRN:   state_d = in_box ? ST_TXT : ST_OUT;
      ST_TXT:   state_d = (ch_ok && faddr_ok) ? ST_FNT : ST_OUT;
      ST_FNT:   state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      res_hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        res_hit_q <= 1'b0;
      end else if (state_q == ST_FNT) begin
        res_hit_q <= glyph_bit && frame_ok;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ox_q     <= offset_x_i;
      oy_q     <= offset_y_i;
      ax_q     <= anchor_x_i;
      ay_q     <= anchor_y_i;
      res_fx_q <= '0;
      res_fy_q <= '0;
    end
    if (state_q == ST_MUL) begin
      mxa_q <= 44'(ox_q) * 44'(inv_st.ia);
      myc_q <= 44'(oy_q) * 44'(inv_st.ic);
      mxb_q <= 44'(ox_q) * 44'(inv_st.ib);
      myd_q <= 44'(oy_q) * 44'(inv_st.id);
    end
    if (state_q == ST_SUM) begin
      rx_q <= 48'(mxa_q) + 48'(myc_q) + 48'(inv_st.itx);
      ry_q <= 48'(mxb_q) + 48'(myd_q) + 48'(inv_st.ity);
    end
    if (state_q == ST_TRN) begin
      col_q <= bx[agp_pkg::GLYPH_BITS-1:0];
      row_q <= by[agp_pkg::GLYPH_BITS-1:0];
    end
    if (state_q == ST_FNT && glyph_bit && frame_ok) begin
      res_fx_q <= agp_pkg::FRAME_XW'(fx);
      res_fy_q <= agp_pkg::FRAME_YW'(fy);
    end
    if (state_q == ST_OUT && out_free) begin
      hit_q  <= res_hit_q;
      pix_q  <= res_hit_q ? {color_q[6:0], 1'b0} : 8'd0;
      fx_q   <= res_fx_q;
      fy_q   <= res_fy_q;
      sing_q <= inv_st.singular;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign pixel_value_o = pix_q;
  assign frame_x_o     = fx_q;
  assign frame_y_o     = fy_q;
  assign singular_o    = sing_q;

  `AGS_ASSERT(a_sing_clear, inv_st.singular, (inv_st.ia == '0) && (inv_st.id == '0) && (inv_st.itx == '0), "singular inverse not cleared")
  `AGS_ASSERT(a_latch_owner, inv_busy, state_q == ST_LATCH, "inverse busy outside latch")
  `AGS_ASSERT(a_hit_pixel, out_valid_o && hit_o, pixel_value_o == {color_q[6:0], 1'b0}, "hit pixel value mismatch")
  `AGS_ASSERT_NEXT(a_out_load, (state_q == ST_OUT) && out_free, out_valid_o && !in_stall_o, "result not delivered to output")

endmodule
